// ----- rtl/core/gbn_pkg.sv -----
// Shared types and constants for the go-back-N sender window.
// No dependencies; used by the interfaces, controller, datapath and top level.
package gbn_pkg;

    // Field widths
    localparam int SeqW   = 16;
    localparam int RepsW  = 5;
    localparam int CntW   = 5;

    // Window limits
    localparam int          Window    = 8;
    localparam int          MaxRes    = 16;
    localparam logic [RepsW-1:0] RepsReset = 5'd4;

    // Event kinds carried by an input word
    typedef enum logic [2:0] {
        FN_START = 3'd0,
        FN_MSG   = 3'd1,
        FN_ACK   = 3'd2,
        FN_TIMER = 3'd3,
        FN_END   = 3'd4
    } t_func;

    // Packet kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_HAND = 2'd2;
    localparam logic [1:0] KIND_ENDS = 2'd3;

    // Timer actions
    localparam logic [1:0] TMR_LEAVE   = 2'd0;
    localparam logic [1:0] TMR_RESTART = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;

    // Link phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HAND = 2'd1,
        PH_XFER = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // How the results of one event are produced
    typedef enum logic [1:0] {
        MD_SINGLE = 2'd0,
        MD_RESEND = 2'd1,
        MD_ENDS   = 2'd2
    } t_mode;

    // Controller to datapath
    typedef struct packed {
        logic take;   // latch the accepted input word
        logic plan;   // decode event, update window state, arm result sequencer
        logic emit;   // load one result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic final_res;  // the pending result is the last one of the event
    } t_sts;

endpackage

// ----- rtl/core/gbn_evt_if.sv -----
// Input channel: one event word per handshake.
// Depends on gbn_pkg for field widths.
interface gbn_evt_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                func;
    logic [gbn_pkg::SeqW-1:0]  ack_number;

    modport source (output valid, output func, output ack_number, input ready);
    modport sink   (input valid, input func, input ack_number, output ready);
endinterface

// ----- rtl/core/gbn_res_if.sv -----
// Output channel: one transmit command word per handshake.
// Depends on gbn_pkg for field widths.
interface gbn_res_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                send_kind;
    logic [gbn_pkg::SeqW-1:0]  send_sequence;
    logic [1:0]                timer_action;
    logic                      accepted;
    logic                      bad_ack;
    logic                      finished;
    logic                      last;

    modport source (output valid, output send_kind, output send_sequence,
                    output timer_action, output accepted, output bad_ack,
                    output finished, output last, input ready);
    modport sink   (input valid, input send_kind, input send_sequence,
                    input timer_action, input accepted, input bad_ack,
                    input finished, input last, output ready);
endinterface

// ----- rtl/core/gbn_ctrl.sv -----
// Sequencing controller: accept an event, plan it, then emit its results.
// Depends on gbn_pkg (command/status structs).
module gbn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_evt_valid,
    output logic              o_evt_ready,
    input  gbn_pkg::t_sts     i_sts,
    output gbn_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_WAIT = 3'b001,
        ST_PLAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Commands
    assign o_evt_ready = (r_state == ST_WAIT);
    assign o_cmd.take  = i_evt_valid && (r_state == ST_WAIT);
    assign o_cmd.plan  = (r_state == ST_PLAN);
    assign o_cmd.emit  = (r_state == ST_EMIT) && i_sts.out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_WAIT: begin
                if (i_evt_valid) n_state = ST_PLAN;
            end
            ST_PLAN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.final_res) n_state = ST_WAIT;
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    // A taken word is always planned in the next cycle
    a_take_then_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> o_cmd.plan)
        else $error("accepted event not planned");

    // Planning is always followed by emitting
    a_plan_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.plan |=> (r_state == ST_EMIT))
        else $error("plan not followed by emit state");

    // No new word is taken while results are still owed
    a_no_take_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_evt_ready)
        else $error("ready raised while emitting");

endmodule

// ----- rtl/core/gbn_dp.sv -----
// Datapath: window state, event decode, result sequencer and output register.
// Depends on gbn_pkg; driven by gbn_ctrl through t_cmd / t_sts.
module gbn_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbn_pkg::t_cmd                i_cmd,
    output gbn_pkg::t_sts                o_sts,
    input  logic [2:0]                   i_func,
    input  logic [gbn_pkg::SeqW-1:0]     i_ack_number,
    input  logic                         i_cfg_we,
    input  logic [gbn_pkg::RepsW-1:0]    i_cfg_wdata,
    gbn_res_if.source                    o_res
);

    localparam int SeqW = gbn_pkg::SeqW;
    localparam int CntW = gbn_pkg::CntW;

    // Window state
    gbn_pkg::t_phase               r_phase;
    logic [SeqW-1:0]               r_base;
    logic [SeqW-1:0]               r_next;
    logic                          r_ended;
    logic [gbn_pkg::RepsW-1:0]     r_reps;

    // Latched event word
    logic [2:0]                    r_func;
    logic [SeqW-1:0]               r_ack;

    // Result sequencer
    gbn_pkg::t_mode                r_mode;
    logic [CntW-1:0]               r_cnt;
    logic [SeqW-1:0]               r_seq;
    logic                          r_first;
    logic [1:0]                    r_s_kind;
    logic [1:0]                    r_s_tmr;
    logic                          r_s_acc;
    logic                          r_s_bad;

    // Output register
    logic                          r_ovalid;
    logic [1:0]                    r_okind;
    logic [SeqW-1:0]               r_oseq;
    logic [1:0]                    r_otmr;
    logic                          r_oacc;
    logic                          r_obad;
    logic                          r_ofin;
    logic                          r_olast;

    // Plan results
    gbn_pkg::t_phase               n_phase;
    logic [SeqW-1:0]               n_base;
    logic [SeqW-1:0]               n_next;
    logic                          n_ended;
    gbn_pkg::t_mode                n_mode;
    logic [CntW-1:0]               n_cnt;
    logic [SeqW-1:0]               n_seq;
    logic [1:0]                    n_s_kind;
    logic [1:0]                    n_s_tmr;
    logic                          n_s_acc;
    logic                          n_s_bad;

    logic [SeqW-1:0]               outst;
    logic [SeqW-1:0]               off;
    logic [SeqW-1:0]               new_base;
    logic                          empty;
    logic [CntW-1:0]               reps_clamped;
    logic [CntW-1:0]               resend_cnt;

    // Results of the pending emit
    logic [1:0]                    e_kind;
    logic [SeqW-1:0]               e_seq;
    logic [1:0]                    e_tmr;
    logic                          e_acc;
    logic                          e_bad;
    logic                          e_fin;
    logic                          e_last;

    // Offsets relative to the base, with wrap
    assign outst    = r_next - r_base;
    assign off      = r_ack - r_base;
    assign new_base = (off == '0) ? r_base : r_ack;
    assign empty    = (r_next == new_base);

    // Endshake count: zero counts as one, capped at the result limit
    always_comb begin
        if (r_reps == '0) begin
            reps_clamped = CntW'(1);
        end else if (r_reps > CntW'(gbn_pkg::MaxRes)) begin
            reps_clamped = CntW'(gbn_pkg::MaxRes);
        end else begin
            reps_clamped = r_reps;
        end
    end

    assign resend_cnt = (outst > SeqW'(gbn_pkg::MaxRes)) ? CntW'(gbn_pkg::MaxRes)
                                                         : outst[CntW-1:0];

    // Event decode
    always_comb begin
        n_phase  = r_phase;
        n_base   = r_base;
        n_next   = r_next;
        n_ended  = r_ended;
        n_mode   = gbn_pkg::MD_SINGLE;
        n_cnt    = CntW'(1);
        n_seq    = '0;
        n_s_kind = gbn_pkg::KIND_NONE;
        n_s_tmr  = gbn_pkg::TMR_LEAVE;
        n_s_acc  = 1'b0;
        n_s_bad  = 1'b0;
        case (gbn_pkg::t_func'(r_func))
            gbn_pkg::FN_START: begin
                if (r_phase == gbn_pkg::PH_IDLE) begin
                    n_phase  = gbn_pkg::PH_HAND;
                    n_s_kind = gbn_pkg::KIND_HAND;
                    n_s_tmr  = gbn_pkg::TMR_RESTART;
                end
            end
            gbn_pkg::FN_MSG: begin
                if (r_phase == gbn_pkg::PH_XFER && !r_ended
                    && outst < SeqW'(gbn_pkg::Window)) begin
                    n_s_kind = gbn_pkg::KIND_DATA;
                    n_seq    = r_next;
                    n_s_tmr  = (outst == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_LEAVE;
                    n_s_acc  = 1'b1;
                    n_next   = r_next + SeqW'(1);
                end
            end
            gbn_pkg::FN_ACK: begin
                if (r_phase == gbn_pkg::PH_HAND) begin
                    if (r_ack <= SeqW'(1)) begin
                        n_phase = gbn_pkg::PH_XFER;
                        n_base  = '0;
                        n_next  = '0;
                        if (r_ended) begin
                            n_phase = gbn_pkg::PH_DONE;
                            n_mode  = gbn_pkg::MD_ENDS;
                            n_cnt   = reps_clamped;
                        end else begin
                            n_s_tmr = gbn_pkg::TMR_STOP;
                        end
                    end
                end else if (r_phase == gbn_pkg::PH_XFER) begin
                    if (off > outst) begin
                        n_s_bad = 1'b1;
                    end else begin
                        n_base = new_base;
                        if (empty && r_ended) begin
                            n_phase = gbn_pkg::PH_DONE;
                            n_mode  = gbn_pkg::MD_ENDS;
                            n_cnt   = reps_clamped;
                            n_seq   = r_next;
                        end else if (off == '0 && outst != '0) begin
                            // duplicate ack: resend the base packet
                            n_s_kind = gbn_pkg::KIND_DATA;
                            n_seq    = r_base;
                            n_s_tmr  = gbn_pkg::TMR_RESTART;
                        end else begin
                            n_s_tmr = empty ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
                        end
                    end
                end
            end
            gbn_pkg::FN_TIMER: begin
                if (r_phase == gbn_pkg::PH_HAND) begin
                    n_s_kind = gbn_pkg::KIND_HAND;
                end else if (r_phase == gbn_pkg::PH_XFER && outst != '0) begin
                    n_mode = gbn_pkg::MD_RESEND;
                    n_cnt  = resend_cnt;
                    n_seq  = r_base;
                end
            end
            gbn_pkg::FN_END: begin
                if (r_phase != gbn_pkg::PH_DONE) n_ended = 1'b1;
                if (r_phase == gbn_pkg::PH_XFER && outst == '0) begin
                    n_phase = gbn_pkg::PH_DONE;
                    n_mode  = gbn_pkg::MD_ENDS;
                    n_cnt   = reps_clamped;
                    n_seq   = r_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Current result from the sequencer
    always_comb begin
        e_kind = r_s_kind;
        e_seq  = r_seq;
        e_tmr  = r_s_tmr;
        e_acc  = r_s_acc;
        e_bad  = r_s_bad;
        e_fin  = 1'b0;
        e_last = 1'b1;
        case (r_mode)
            gbn_pkg::MD_SINGLE: begin
            end
            gbn_pkg::MD_RESEND: begin
                e_kind = gbn_pkg::KIND_DATA;
                e_tmr  = gbn_pkg::TMR_LEAVE;
                e_acc  = 1'b0;
                e_bad  = 1'b0;
                e_last = (r_cnt == CntW'(1));
            end
            gbn_pkg::MD_ENDS: begin
                e_kind = gbn_pkg::KIND_ENDS;
                e_tmr  = r_first ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_LEAVE;
                e_acc  = 1'b0;
                e_bad  = 1'b0;
                e_fin  = (r_cnt == CntW'(1));
                e_last = (r_cnt == CntW'(1));
            end
            default: begin
            end
        endcase
    end

    assign o_sts.out_free  = !r_ovalid || o_res.ready;
    assign o_sts.final_res = e_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= gbn_pkg::PH_IDLE;
            r_base   <= '0;
            r_next   <= '0;
            r_ended  <= 1'b0;
            r_reps   <= gbn_pkg::RepsReset;
            r_mode   <= gbn_pkg::MD_SINGLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_reps <= i_cfg_wdata;
            if (i_cmd.plan) begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_next  <= n_next;
                r_ended <= n_ended;
                r_mode  <= n_mode;
                r_cnt   <= n_cnt;
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt - CntW'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func <= i_func;
            r_ack  <= i_ack_number;
        end
        if (i_cmd.plan) begin
            r_seq    <= n_seq;
            r_first  <= 1'b1;
            r_s_kind <= n_s_kind;
            r_s_tmr  <= n_s_tmr;
            r_s_acc  <= n_s_acc;
            r_s_bad  <= n_s_bad;
        end else if (i_cmd.emit) begin
            // a resend walks up the window; endshakes all carry the same sequence
            if (r_mode == gbn_pkg::MD_RESEND) r_seq <= r_seq + SeqW'(1);
            r_first <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_okind <= e_kind;
            r_oseq  <= e_seq;
            r_otmr  <= e_tmr;
            r_oacc  <= e_acc;
            r_obad  <= e_bad;
            r_ofin  <= e_fin;
            r_olast <= e_last;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.send_kind     = r_okind;
    assign o_res.send_sequence = r_oseq;
    assign o_res.timer_action  = r_otmr;
    assign o_res.accepted      = r_oacc;
    assign o_res.bad_ack       = r_obad;
    assign o_res.finished      = r_ofin;
    assign o_res.last          = r_olast;

    // Never more than a window of packets outstanding
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_base) <= SeqW'(gbn_pkg::Window))
        else $error("outstanding count exceeds window");

    // A looping sequencer never runs with an empty count
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_mode != gbn_pkg::MD_SINGLE) |-> (r_cnt != '0))
        else $error("result sequencer underflow");

    // The closing word of the link is always the last of its event
    a_fin_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofin) |-> (r_olast && r_okind == gbn_pkg::KIND_ENDS))
        else $error("finished word not last endshake");

    // After the link closes the phase stays closed
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == gbn_pkg::PH_DONE) |=> (r_phase == gbn_pkg::PH_DONE))
        else $error("phase left closed state");

endmodule

// ----- rtl/core/go_back_n_sender_window.sv -----
// Go-back-N sender window, top level: controller plus datapath.
// Depends on gbn_pkg, gbn_evt_if, gbn_res_if, gbn_ctrl and gbn_dp.
//
// Takes one event word (start, message ready, ack, timer expiry, end of
// input) and answers with one or more transmit command words, the final one
// marked last. Events are handled one at a time: each event is latched, then
// decoded while the window is updated, then its words are emitted one per
// cycle unless the output channel stalls; a timer expiry gives up to WINDOW
// words and an endshake up to 16. The pace is set by the one-word-per-cycle
// result sequencer feeding a single output register; a stall on the output
// channel stretches the emit phase. The next event is accepted once the last
// word has entered the output register, even if that word has not yet been
// taken. The user must write endshake_repeats through i_cfg_we / i_cfg_wdata
// only while no event is in flight; the block does not enforce it. Resets to 4.
module go_back_n_sender_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gbn_evt_if.sink                      i_evt,
    gbn_res_if.source                    o_res,
    input  logic                         i_cfg_we,
    input  logic [gbn_pkg::RepsW-1:0]    i_cfg_wdata
);

    gbn_pkg::t_cmd cmd;
    gbn_pkg::t_sts sts;

    // Sequencing
    gbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (i_evt.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Window state and result generation
    gbn_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_evt.func),
        .i_ack_number (i_evt.ack_number),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res        (o_res)
    );

endmodule
